// ===== hw/rtl/bsr_pkg.sv =====
package bsr_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_VALUE_WIDTH = 32;
    localparam int unsigned DEF_FRAC_BITS   = 16;

    // Fixed field widths
    localparam int unsigned TOL_W     = 16;
    localparam int unsigned LIM_W     = 6;
    localparam int unsigned ROOT_W    = 24;
    localparam int unsigned STEPS_W   = 6;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_TOL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;
    localparam logic [TOL_W-1:0]     TOL_RESET   = 16'd655;
    localparam logic [LIM_W-1:0]     LIMIT_RESET = 6'd48;

    // Microprogram step counter
    localparam int unsigned UPC_W = 4;

    localparam logic [UPC_W-1:0] ST_WAIT     = 4'd0;
    localparam logic [UPC_W-1:0] ST_PRE_LL   = 4'd1;
    localparam logic [UPC_W-1:0] ST_PRE_HL   = 4'd2;
    localparam logic [UPC_W-1:0] ST_PRE_HH   = 4'd3;
    localparam logic [UPC_W-1:0] ST_CHK      = 4'd4;
    localparam logic [UPC_W-1:0] ST_MID      = 4'd5;
    localparam logic [UPC_W-1:0] ST_LOOP     = 4'd6;
    localparam logic [UPC_W-1:0] ST_LOOP_HL  = 4'd7;
    localparam logic [UPC_W-1:0] ST_LOOP_HH  = 4'd8;
    localparam logic [UPC_W-1:0] ST_TEST     = 4'd9;
    localparam logic [UPC_W-1:0] ST_BISECT   = 4'd10;
    localparam logic [UPC_W-1:0] ST_EMIT     = 4'd11;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,    // take request, set bounds and first guess
        OP_SQ_LL,   // acc = xl*xl
        OP_SQ_HL,   // acc += 2*xh*xl << H
        OP_SQ_HH,   // acc += xh*xh << 2H
        OP_MID,     // x = (lo + hi) / 2
        OP_BISECT,  // move one bound to x, step count + 1, new midpoint
        OP_EMIT     // write result register
    } bsr_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_VALID,
        COND_EXACT,
        COND_FINISH,
        COND_OUT_FREE
    } bsr_cond_t;

    // One control word: op, jump condition, hold-on-false, jump target
    typedef struct packed {
        bsr_op_t          op;
        bsr_cond_t        cond;
        logic             hold;
        logic [UPC_W-1:0] target;
    } bsr_cw_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic exact;
        logic finish;
        logic out_free;
    } bsr_status_t;

    // Control store
    function automatic bsr_cw_t ucode(input logic [UPC_W-1:0] upc);
        bsr_cw_t w;
        w = '{OP_NOP, COND_ALWAYS, 1'b0, ST_WAIT};
        unique case (upc)
            ST_WAIT:    w = '{OP_LOAD,   COND_IN_VALID, 1'b1, ST_PRE_LL};
            ST_PRE_LL:  w = '{OP_SQ_LL,  COND_NEVER,    1'b0, ST_WAIT};
            ST_PRE_HL:  w = '{OP_SQ_HL,  COND_NEVER,    1'b0, ST_WAIT};
            ST_PRE_HH:  w = '{OP_SQ_HH,  COND_NEVER,    1'b0, ST_WAIT};
            ST_CHK:     w = '{OP_NOP,    COND_EXACT,    1'b0, ST_EMIT};
            ST_MID:     w = '{OP_MID,    COND_NEVER,    1'b0, ST_WAIT};
            ST_LOOP:    w = '{OP_SQ_LL,  COND_NEVER,    1'b0, ST_WAIT};
            ST_LOOP_HL: w = '{OP_SQ_HL,  COND_NEVER,    1'b0, ST_WAIT};
            ST_LOOP_HH: w = '{OP_SQ_HH,  COND_NEVER,    1'b0, ST_WAIT};
            ST_TEST:    w = '{OP_NOP,    COND_FINISH,   1'b0, ST_EMIT};
            ST_BISECT:  w = '{OP_BISECT, COND_ALWAYS,   1'b0, ST_LOOP};
            ST_EMIT:    w = '{OP_EMIT,   COND_OUT_FREE, 1'b1, ST_WAIT};
            default:    w = '{OP_NOP,    COND_ALWAYS,   1'b0, ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/bsr_if.sv =====
interface bsr_in_if
    import bsr_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_VALUE_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bsr_out_if
    import bsr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ROOT_W-1:0]  root;
    logic [STEPS_W-1:0] steps;
    logic               converged;

    modport source (output valid, output root, output steps, output converged, input ready);
    modport sink   (input valid, input root, input steps, input converged, output ready);
endinterface

// ===== hw/rtl/bsr_seq.sv =====
module bsr_seq
    import bsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  bsr_status_t status,
    output bsr_cw_t     cw,
    output logic        adv
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             cond_true;

    assign cw = ucode(upc_reg);

    always_comb
    begin
        unique case (cw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_IN_VALID: cond_true = in_valid;
            COND_EXACT:    cond_true = status.exact;
            COND_FINISH:   cond_true = status.finish;
            COND_OUT_FREE: cond_true = status.out_free;
            default:       cond_true = 1'b1;
        endcase
    end

    // a holding step stays put until its condition comes true
    assign adv = cond_true || !cw.hold;

    always_comb
    begin
        if (cond_true)
        begin
            upc_next = cw.target;
        end
        else if (cw.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    a_load_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cw.op == OP_LOAD |=> upc_reg == ST_PRE_LL)
        else $error("load not followed by first partial product");

    a_hold_keeps_step: assert property (@(posedge clk) disable iff (!rst_n)
        cw.hold && !adv |=> $stable(upc_reg))
        else $error("step counter moved while holding");

endmodule

// ===== hw/rtl/bsr_datapath.sv =====
module bsr_datapath
    import bsr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bsr_cw_t                cw,
    input  logic                   adv,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [TOL_W-1:0]       tolerance,
    input  logic [LIM_W-1:0]       limit,
    input  logic                   out_ready,
    output bsr_status_t            status,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output logic [STEPS_W-1:0]     steps,
    output logic                   converged
);

    // bound width: holds the value and the constant one
    localparam int unsigned ONE_W = FRAC_BITS + 1;
    localparam int unsigned BW    = (VALUE_WIDTH > ONE_W) ? VALUE_WIDTH : ONE_W;
    localparam int unsigned H     = (BW + 1) / 2;
    localparam int unsigned SQW   = 2 * BW;
    localparam int unsigned TLW   = TOL_W + FRAC_BITS;
    localparam int unsigned CW0   = (SQW > TLW) ? SQW : TLW;
    localparam int unsigned CW    = CW0 + 1;
    localparam int unsigned XW    = (BW > ROOT_W) ? BW : ROOT_W;

    localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;

    logic [BW-1:0]      x_reg, x_next;
    logic [BW-1:0]      lo_reg, lo_next;
    logic [BW-1:0]      hi_reg, hi_next;
    logic [SQW-1:0]     acc_reg, acc_next;
    logic [CW-1:0]      tgt_reg, tgt_next;
    logic [CW-1:0]      tplus_reg, tplus_next;
    logic [CW-1:0]      tminus_reg, tminus_next;
    logic               tmin_ok_reg, tmin_ok_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    logic               out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEPS_W-1:0] osteps_reg, osteps_next;
    logic               conv_reg, conv_next;

    logic [BW-1:0]      v_ext;
    logic [BW-1:0]      hi_load;
    logic [CW-1:0]      t_load;
    logic [CW-1:0]      tol_sh;

    logic [H-1:0]       xl, xh, mul_a, mul_b;
    logic [2*H-1:0]     prod;
    logic [SQW-1:0]     prod_w;

    logic [CW-1:0]      acc_c;
    logic               exact, below, near, conv;

    logic [BW-1:0]      lo_sel, hi_sel;
    logic [BW:0]        mid_sum;

    logic [XW-1:0]      x_ext;
    logic               sat;

    // request set-up
    assign v_ext   = BW'(value);
    assign hi_load = (v_ext < ONE) ? ONE : v_ext;
    assign t_load  = CW'(value) << FRAC_BITS;
    assign tol_sh  = CW'(tolerance) << FRAC_BITS;

    // one H x H multiplier, three partial products per square
    assign xl     = x_reg[H-1:0];
    assign xh     = H'(x_reg >> H);
    assign mul_a  = (cw.op == OP_SQ_HL || cw.op == OP_SQ_HH) ? xh : xl;
    assign mul_b  = (cw.op == OP_SQ_HH) ? xh : xl;
    assign prod   = mul_a * mul_b;
    assign prod_w = SQW'(prod);

    // |acc - t| < tol  <=>  t - tol < acc < t + tol
    assign acc_c = CW'(acc_reg);
    assign exact = (acc_c == tgt_reg);
    assign below = (acc_c < tgt_reg);
    assign near  = (acc_c < tplus_reg) && (!tmin_ok_reg || acc_c > tminus_reg);
    assign conv  = exact || near;

    assign status.exact    = exact;
    assign status.finish   = conv || (steps_reg >= limit);
    assign status.out_free = !out_valid_reg || out_ready;

    // bisection: move a bound to x, then take the new midpoint
    assign lo_sel  = (cw.op == OP_BISECT && below)  ? x_reg : lo_reg;
    assign hi_sel  = (cw.op == OP_BISECT && !below) ? x_reg : hi_reg;
    assign mid_sum = (BW+1)'(lo_sel) + (BW+1)'(hi_sel);

    assign x_ext = XW'(x_reg);
    assign sat   = x_ext > XW'(ROOT_MAX);

    always_comb
    begin
        x_next         = x_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        tgt_next       = tgt_reg;
        tplus_next     = tplus_reg;
        tminus_next    = tminus_reg;
        tmin_ok_next   = tmin_ok_reg;
        steps_next     = steps_reg;
        root_next      = root_reg;
        osteps_next    = osteps_reg;
        conv_next      = conv_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (adv)
        begin
            unique case (cw.op)
                OP_NOP:
                begin
                end
                OP_LOAD:
                begin
                    lo_next      = '0;
                    hi_next      = hi_load;
                    // zero squares to zero and leaves at the endpoint check
                    x_next       = (v_ext == '0) ? '0 : hi_load;
                    steps_next   = '0;
                    tgt_next     = t_load;
                    tplus_next   = t_load + tol_sh;
                    tminus_next  = t_load - tol_sh;
                    tmin_ok_next = (t_load >= tol_sh);
                end
                OP_SQ_LL:
                begin
                    acc_next = prod_w;
                end
                OP_SQ_HL:
                begin
                    acc_next = acc_reg + (prod_w << (H + 1));
                end
                OP_SQ_HH:
                begin
                    acc_next = acc_reg + (prod_w << (2 * H));
                end
                OP_MID:
                begin
                    x_next = mid_sum[BW:1];
                end
                OP_BISECT:
                begin
                    lo_next    = lo_sel;
                    hi_next    = hi_sel;
                    x_next     = mid_sum[BW:1];
                    steps_next = steps_reg + STEPS_W'(1);
                end
                OP_EMIT:
                begin
                    out_valid_next = 1'b1;
                    root_next      = sat ? ROOT_MAX : x_ext[ROOT_W-1:0];
                    osteps_next    = steps_reg;
                    conv_next      = conv;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        acc_reg     <= acc_next;
        tgt_reg     <= tgt_next;
        tplus_reg   <= tplus_next;
        tminus_reg  <= tminus_next;
        tmin_ok_reg <= tmin_ok_next;
        steps_reg   <= steps_next;
        root_reg    <= root_next;
        osteps_reg  <= osteps_next;
        conv_reg    <= conv_next;
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign steps     = osteps_reg;
    assign converged = conv_reg;

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cw.op == OP_EMIT |=> out_valid_reg)
        else $error("emit did not fill the result register");

    a_bisect_counts: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cw.op == OP_BISECT |=> steps_reg == $past(steps_reg) + STEPS_W'(1))
        else $error("bisection step not counted");

endmodule

// ===== hw/rtl/bisection_square_root.sv =====
// Channel   Dir  Payload                           Meaning
// sample    in   value[VALUE_WIDTH-1:0]            unsigned fixed point, FRAC_BITS fraction
// result    out  root[23:0] steps[5:0] converged   root (saturated), steps taken, met tol
// cfg       in   cfg_we cfg_index cfg_data         0: tolerance[15:0], 1: iteration_limit[5:0]
//
// A request ends after the first check when the value is zero or an endpoint is an exact
// root, otherwise after s bisection steps (s <= iteration_limit).
// Each step squares the midpoint as three partial products on one shared
// multiplier, then tests and moves a bound; that loop sets the rate.
// Reset clears the step counter, result valid and the config registers (655, 48).
// A result waiting on result.ready holds only the final emit step; the next
// request is taken once it leaves.
module bisection_square_root
    import bsr_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    bsr_in_if.sink               sample,
    bsr_out_if.source            result
);

    // configuration registers
    logic [TOL_W-1:0] tol_reg, tol_next;
    logic [LIM_W-1:0] limit_reg, limit_next;

    // sequencer <-> datapath
    bsr_cw_t     cw;
    logic        adv;
    bsr_status_t status;

    always_comb
    begin
        tol_next   = tol_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOL:   tol_next   = cfg_data[TOL_W-1:0];
                REG_LIMIT: limit_next = cfg_data[LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            tol_reg   <= tol_next;
            limit_reg <= limit_next;
        end
    end

    // the load step is the only one that takes a request
    assign sample.ready = (cw.op == OP_LOAD);

    bsr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .status   (status),
        .cw       (cw),
        .adv      (adv)
    );

    bsr_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .adv       (adv),
        .value     (sample.value),
        .tolerance (tol_reg),
        .limit     (limit_reg),
        .out_ready (result.ready),
        .status    (status),
        .out_valid (result.valid),
        .root      (result.root),
        .steps     (result.steps),
        .converged (result.converged)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("request taken while another is in flight");

endmodule
